>>> src/sdtw_pkg.sv
// sdtw_pkg: shared types and constants of the spike delay timing wheel
// opcodes, status codes, config indexes, control states and command bundles
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package sdtw_pkg;

  typedef enum logic [1:0] {
    OP_SCHEDULE   = 2'd0,
    OP_READ_FIRST = 2'd1,
    OP_READ_NEXT  = 2'd2,
    OP_ADVANCE    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_POOL_FULL   = 2'd1,
    ST_DELAY_RANGE = 2'd2
  } status_e;

  typedef enum logic {
    CFG_MIN_DELAY = 1'b0,
    CFG_MAX_DELAY = 1'b1
  } cfg_idx_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_SCH_WR,
    S_SCH_LINK,
    S_MOD,
    S_RF_SLOT,
    S_NODE_RD,
    S_ADV_WR,
    S_RESP
  } state_e;

  localparam int unsigned SLOTS     = 64;
  localparam int unsigned MIN_W     = 5;
  localparam int unsigned MAX_W     = 6;
  localparam int unsigned CFG_DW    = 6;
  localparam int unsigned GROUP_W   = 8;
  localparam int unsigned DELAY_W   = 6;
  localparam int unsigned OFFSET_W  = 7;
  localparam int unsigned CUR_W     = 6;
  localparam int unsigned LEN_W     = 7;
  localparam int unsigned MOD_W     = 13;
  localparam int unsigned MOD_STEPS = 13;
  localparam int unsigned MOD_CNT_W = 4;
  localparam int unsigned DIV_W     = MOD_W + LEN_W - 1;

  localparam logic [MIN_W-1:0] MIN_DELAY_RST = 5'd1;
  localparam logic [MAX_W-1:0] MAX_DELAY_RST = 6'd20;

  typedef struct packed {
    logic wr_full;
    logic wr_link;
    logic rd;
  } node_cmd_t;

  typedef struct packed {
    logic rd;
    logic wr;
    logic occ_wr;
    logic occ_val;
    logic clear;
  } slot_cmd_t;

endpackage

`default_nettype wire

>>> src/spike_delay_timing_wheel.sv
// spike_delay_timing_wheel: timing wheel of delay slots holding spike events
// control sequencer on top of sdtw_slot_table, sdtw_node_store, sdtw_slot_mod
// depends on sdtw_pkg
//
// usage: one command beat in on s_axis (opcode in tuser), one result beat out
// on m_axis for every command. schedule appends an event to the slot at
// current+delay, read_first returns the head of slot current+offset,
// read_next follows the read cursor, advance recycles the current slot and
// steps the wheel. the ring length is min_delay+max_delay+1, capped at SLOTS.
// one command is worked on at a time. schedule reads the slot, then writes the
// node and the slot entry, plus a link write to the tail node when the slot
// already holds events; read_next reads the node at the read cursor; advance
// first links an occupied slot onto the recycle list; read_first waits for the
// 13-step remainder unit that folds the signed offset into the ring, then reads
// an occupied slot and its head node. the next beat is taken once back in idle.
// a stalled receiver holds the result in the output register; a finished
// command then parks its result in a holding register and waits for it.
// reset, or a config write, empties all slots, the recycle list, the node
// pool and the cursor at once; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module spike_delay_timing_wheel #(
  parameter int unsigned NODES       = 1024,
  parameter int unsigned NEURON_BITS = 20
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [0:0]                             cfg_idx_i,
  input  logic [sdtw_pkg::CFG_DW-1:0]            cfg_data_i,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // neuron_id, group_id, spike_delay, slot_offset
  input  logic [((NEURON_BITS+28)/8)*8-1:0]      s_axis_tdata,
  // opcode
  input  logic [1:0]                             s_axis_tuser,
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // neuron_out, group_out, delay_out
  output logic [((NEURON_BITS+21)/8)*8-1:0]      m_axis_tdata,
  // spike_valid, status
  output logic [2:0]                             m_axis_tuser,
  // last_in_slot
  output logic                                   m_axis_tlast
);

  localparam int unsigned NW     = $clog2(NODES);
  localparam int unsigned OCC_N  = sdtw_pkg::SLOTS;
  localparam int unsigned OW     = $clog2(OCC_N);
  localparam int unsigned PW     = NEURON_BITS + sdtw_pkg::GROUP_W + sdtw_pkg::DELAY_W;
  localparam int unsigned RES_W  = PW + 4;
  localparam int unsigned OUT_DW = ((NEURON_BITS + 21) / 8) * 8;

  sdtw_pkg::state_e               state_q, state_d;
  logic [sdtw_pkg::MIN_W-1:0]     min_q;
  logic [sdtw_pkg::MAX_W-1:0]     max_q;
  sdtw_pkg::op_e                  op_q, op_d;
  logic [PW-1:0]                  pay_q, pay_d;
  logic [sdtw_pkg::OFFSET_W-1:0]  off_q, off_d;
  logic [sdtw_pkg::CUR_W-1:0]     cur_q, cur_d;
  logic [NW:0]                    fresh_q, fresh_d;
  logic [NW-1:0]                  rec_head_q, rec_head_d;
  logic                           rec_valid_q, rec_valid_d;
  logic [NW-1:0]                  cursor_q, cursor_d;
  logic                           cursor_valid_q, cursor_valid_d;
  logic [NW-1:0]                  idx_q, idx_d;
  logic [OW-1:0]                  slot_q, slot_d;
  logic                           recyc_q, recyc_d;
  logic                           m_valid_q, m_valid_d;
  logic [RES_W-1:0]               out_q, out_d;
  logic [RES_W-1:0]               res_q, res_d;

  logic [sdtw_pkg::LEN_W-1:0]     ring_sum, ring_len;
  logic [sdtw_pkg::DELAY_W-1:0]   delay_f;
  logic [sdtw_pkg::LEN_W-1:0]     sch_sum, cur_inc;
  logic [sdtw_pkg::CUR_W-1:0]     sch_slot, cur_step;
  logic [sdtw_pkg::MOD_W:0]       mod_x;
  logic                           out_free;
  logic                           emit;
  logic [RES_W-1:0]               emit_res;

  sdtw_pkg::slot_cmd_t            slot_cmd;
  logic [OW-1:0]                  slot_raddr, slot_waddr, slot_qaddr;
  logic [NW-1:0]                  slot_whead, slot_head, slot_tail;
  logic                           slot_occ;

  sdtw_pkg::node_cmd_t            node_cmd;
  logic [NW-1:0]                  node_waddr, node_wnxt, node_raddr, node_rnxt;
  logic                           node_whas, node_rhas;
  logic [PW-1:0]                  node_rpay;

  logic                           mod_start, mod_done;
  logic [sdtw_pkg::CUR_W-1:0]     mod_rem;

  // ring length and slot arithmetic
  assign ring_sum = sdtw_pkg::LEN_W'(min_q) + sdtw_pkg::LEN_W'(max_q) + sdtw_pkg::LEN_W'(1);
  assign ring_len = (32'(ring_sum) > sdtw_pkg::SLOTS) ? sdtw_pkg::LEN_W'(sdtw_pkg::SLOTS)
                                                      : ring_sum;
  assign delay_f  = pay_q[PW-1:PW-sdtw_pkg::DELAY_W];
  assign sch_sum  = sdtw_pkg::LEN_W'(cur_q) + sdtw_pkg::LEN_W'(delay_f);
  assign sch_slot = (sch_sum >= ring_len) ? sdtw_pkg::CUR_W'(sch_sum - ring_len)
                                          : sch_sum[sdtw_pkg::CUR_W-1:0];
  assign cur_inc  = sdtw_pkg::LEN_W'(cur_q) + sdtw_pkg::LEN_W'(1);
  assign cur_step = (cur_inc >= ring_len) ? '0 : cur_inc[sdtw_pkg::CUR_W-1:0];
  // 64*len keeps the sum non-negative for any offset
  assign mod_x    = {1'b0, ring_len, 6'b000000} + (sdtw_pkg::MOD_W + 1)'(cur_q)
                  + {{(sdtw_pkg::MOD_W + 1 - sdtw_pkg::OFFSET_W){off_q[sdtw_pkg::OFFSET_W-1]}},
                     off_q};

  assign out_free      = !m_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == sdtw_pkg::S_IDLE);

  always_comb begin
    state_d        = state_q;
    op_d           = op_q;
    pay_d          = pay_q;
    off_d          = off_q;
    cur_d          = cur_q;
    fresh_d        = fresh_q;
    rec_head_d     = rec_head_q;
    rec_valid_d    = rec_valid_q;
    cursor_d       = cursor_q;
    cursor_valid_d = cursor_valid_q;
    idx_d          = idx_q;
    slot_d         = slot_q;
    recyc_d        = recyc_q;
    m_valid_d      = m_valid_q && !m_axis_tready;
    out_d          = out_q;
    res_d          = res_q;
    emit           = 1'b0;
    emit_res       = '0;
    slot_cmd       = '0;
    slot_cmd.clear = cfg_we_i;
    slot_raddr     = '0;
    slot_waddr     = '0;
    slot_whead     = '0;
    slot_qaddr     = '0;
    node_cmd       = '0;
    node_waddr     = '0;
    node_wnxt      = '0;
    node_whas      = 1'b0;
    node_raddr     = '0;
    mod_start      = 1'b0;

    unique case (state_q)
      sdtw_pkg::S_IDLE: begin
        if (s_axis_tvalid) begin
          op_d    = sdtw_pkg::op_e'(s_axis_tuser);
          pay_d   = s_axis_tdata[PW-1:0];
          off_d   = s_axis_tdata[PW+sdtw_pkg::OFFSET_W-1:PW];
          state_d = sdtw_pkg::S_EXEC;
        end
      end
      sdtw_pkg::S_EXEC: begin
        unique case (op_q)
          sdtw_pkg::OP_SCHEDULE: begin
            if (sdtw_pkg::LEN_W'(delay_f) >= ring_len) begin
              emit     = 1'b1;
              emit_res = RES_W'(sdtw_pkg::ST_DELAY_RANGE);
            end else if (!rec_valid_q && fresh_q == (NW + 1)'(NODES)) begin
              emit     = 1'b1;
              emit_res = RES_W'(sdtw_pkg::ST_POOL_FULL);
            end else begin
              recyc_d      = rec_valid_q;
              idx_d        = rec_valid_q ? rec_head_q : fresh_q[NW-1:0];
              if (!rec_valid_q) begin
                fresh_d = fresh_q + (NW + 1)'(1);
              end
              node_cmd.rd  = rec_valid_q;
              node_raddr   = rec_head_q;
              slot_d       = OW'(sch_slot);
              slot_cmd.rd  = 1'b1;
              slot_raddr   = OW'(sch_slot);
              state_d      = sdtw_pkg::S_SCH_WR;
            end
          end
          sdtw_pkg::OP_READ_FIRST: begin
            mod_start = 1'b1;
            state_d   = sdtw_pkg::S_MOD;
          end
          sdtw_pkg::OP_READ_NEXT: begin
            if (cursor_valid_q && {1'b0, cursor_q} < (NW + 1)'(NODES)) begin
              node_cmd.rd = 1'b1;
              node_raddr  = cursor_q;
              state_d     = sdtw_pkg::S_NODE_RD;
            end else begin
              emit     = 1'b1;
              emit_res = RES_W'(sdtw_pkg::ST_OK);
            end
          end
          sdtw_pkg::OP_ADVANCE: begin
            slot_qaddr = OW'(cur_q);
            if (slot_occ) begin
              slot_cmd.rd = 1'b1;
              slot_raddr  = OW'(cur_q);
              state_d     = sdtw_pkg::S_ADV_WR;
            end else begin
              cur_d    = cur_step;
              emit     = 1'b1;
              emit_res = RES_W'(sdtw_pkg::ST_OK);
            end
          end
          default: ;
        endcase
      end
      sdtw_pkg::S_SCH_WR: begin
        if (recyc_q) begin
          rec_head_d  = node_rnxt;
          rec_valid_d = node_rhas;
        end
        node_cmd.wr_full = 1'b1;
        node_waddr       = idx_q;
        slot_qaddr       = slot_q;
        slot_cmd.wr      = 1'b1;
        slot_cmd.occ_wr  = 1'b1;
        slot_cmd.occ_val = 1'b1;
        slot_waddr       = slot_q;
        slot_whead       = slot_occ ? slot_head : idx_q;
        if (slot_occ) begin
          state_d = sdtw_pkg::S_SCH_LINK;
        end else begin
          emit     = 1'b1;
          emit_res = RES_W'(sdtw_pkg::ST_OK);
        end
      end
      sdtw_pkg::S_SCH_LINK: begin
        node_cmd.wr_link = 1'b1;
        node_waddr       = slot_tail;
        node_wnxt        = idx_q;
        node_whas        = 1'b1;
        emit             = 1'b1;
        emit_res         = RES_W'(sdtw_pkg::ST_OK);
      end
      sdtw_pkg::S_MOD: begin
        if (mod_done) begin
          slot_qaddr = OW'(mod_rem);
          if (slot_occ) begin
            slot_cmd.rd = 1'b1;
            slot_raddr  = OW'(mod_rem);
            state_d     = sdtw_pkg::S_RF_SLOT;
          end else begin
            cursor_valid_d = 1'b0;
            emit           = 1'b1;
            emit_res       = RES_W'(sdtw_pkg::ST_OK);
          end
        end
      end
      sdtw_pkg::S_RF_SLOT: begin
        node_cmd.rd = 1'b1;
        node_raddr  = slot_head;
        state_d     = sdtw_pkg::S_NODE_RD;
      end
      sdtw_pkg::S_NODE_RD: begin
        cursor_d       = node_rnxt;
        cursor_valid_d = node_rhas;
        emit           = 1'b1;
        emit_res       = {1'b1, node_rpay, !node_rhas, sdtw_pkg::ST_OK};
      end
      sdtw_pkg::S_ADV_WR: begin
        // slot list goes in front of the recycle list
        node_cmd.wr_link = 1'b1;
        node_waddr       = slot_tail;
        node_wnxt        = rec_head_q;
        node_whas        = rec_valid_q;
        rec_head_d       = slot_head;
        rec_valid_d      = 1'b1;
        slot_cmd.occ_wr  = 1'b1;
        slot_cmd.occ_val = 1'b0;
        slot_waddr       = OW'(cur_q);
        cur_d            = cur_step;
        emit             = 1'b1;
        emit_res         = RES_W'(sdtw_pkg::ST_OK);
      end
      sdtw_pkg::S_RESP: begin
        if (out_free) begin
          out_d     = res_q;
          m_valid_d = 1'b1;
          state_d   = sdtw_pkg::S_IDLE;
        end
      end
      default: state_d = sdtw_pkg::S_IDLE;
    endcase

    if (emit) begin
      if (out_free) begin
        out_d     = emit_res;
        m_valid_d = 1'b1;
        state_d   = sdtw_pkg::S_IDLE;
      end else begin
        res_d   = emit_res;
        state_d = sdtw_pkg::S_RESP;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= sdtw_pkg::S_IDLE;
      min_q          <= sdtw_pkg::MIN_DELAY_RST;
      max_q          <= sdtw_pkg::MAX_DELAY_RST;
      cur_q          <= '0;
      fresh_q        <= '0;
      rec_head_q     <= '0;
      rec_valid_q    <= 1'b0;
      cursor_q       <= '0;
      cursor_valid_q <= 1'b0;
      m_valid_q      <= 1'b0;
    end else begin
      state_q        <= state_d;
      m_valid_q      <= m_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          sdtw_pkg::CFG_MIN_DELAY: min_q <= cfg_data_i[sdtw_pkg::MIN_W-1:0];
          sdtw_pkg::CFG_MAX_DELAY: max_q <= cfg_data_i[sdtw_pkg::MAX_W-1:0];
          default: ;
        endcase
        cur_q          <= '0;
        fresh_q        <= '0;
        rec_head_q     <= '0;
        rec_valid_q    <= 1'b0;
        cursor_q       <= '0;
        cursor_valid_q <= 1'b0;
      end else begin
        cur_q          <= cur_d;
        fresh_q        <= fresh_d;
        rec_head_q     <= rec_head_d;
        rec_valid_q    <= rec_valid_d;
        cursor_q       <= cursor_d;
        cursor_valid_q <= cursor_valid_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    pay_q   <= pay_d;
    off_q   <= off_d;
    idx_q   <= idx_d;
    slot_q  <= slot_d;
    recyc_q <= recyc_d;
    out_q   <= out_d;
    res_q   <= res_d;
  end

  sdtw_slot_table #(
    .DEPTH (OCC_N),
    .AW    (OW),
    .NW    (NW)
  ) u_slot_table (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (slot_cmd),
    .raddr_i (slot_raddr),
    .waddr_i (slot_waddr),
    .whead_i (slot_whead),
    .wtail_i (idx_q),
    .qaddr_i (slot_qaddr),
    .head_o  (slot_head),
    .tail_o  (slot_tail),
    .occ_o   (slot_occ)
  );

  sdtw_node_store #(
    .DEPTH (NODES),
    .AW    (NW),
    .PW    (PW)
  ) u_node_store (
    .clk_i   (clk_i),
    .cmd_i   (node_cmd),
    .waddr_i (node_waddr),
    .wpay_i  (pay_q),
    .wnxt_i  (node_wnxt),
    .whas_i  (node_whas),
    .raddr_i (node_raddr),
    .rpay_o  (node_rpay),
    .rnxt_o  (node_rnxt),
    .rhas_o  (node_rhas)
  );

  sdtw_slot_mod u_slot_mod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mod_start),
    .x_i     (mod_x[sdtw_pkg::MOD_W-1:0]),
    .len_i   (ring_len),
    .done_o  (mod_done),
    .rem_o   (mod_rem)
  );

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = OUT_DW'(out_q[PW+2:3]);
  assign m_axis_tuser  = {out_q[1:0], out_q[RES_W-1]};
  assign m_axis_tlast  = out_q[2];

endmodule

`default_nettype wire

>>> src/sdtw_slot_mod.sv
// sdtw_slot_mod: iterative remainder unit, one restoring step per cycle
// reduces a non-negative slot sum into 0..len-1
// depends on sdtw_pkg
`timescale 1ns / 1ps
`default_nettype none

module sdtw_slot_mod (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [sdtw_pkg::MOD_W-1:0]   x_i,
  input  logic [sdtw_pkg::LEN_W-1:0]   len_i,
  output logic                         done_o,
  output logic [sdtw_pkg::CUR_W-1:0]   rem_o
);

  logic [sdtw_pkg::MOD_W-1:0]     rem_q, rem_d;
  logic [sdtw_pkg::DIV_W-1:0]     div_q, div_d;
  logic [sdtw_pkg::MOD_CNT_W-1:0] cnt_q, cnt_d;
  logic                           busy_q, busy_d;
  logic                           done_q, done_d;

  always_comb begin
    rem_d  = rem_q;
    div_d  = div_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = x_i;
      div_d  = sdtw_pkg::DIV_W'(len_i) << (sdtw_pkg::MOD_STEPS - 1);
      cnt_d  = sdtw_pkg::MOD_CNT_W'(sdtw_pkg::MOD_STEPS - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (sdtw_pkg::DIV_W'(rem_q) >= div_q) begin
        rem_d = rem_q - div_q[sdtw_pkg::MOD_W-1:0];
      end
      div_d = div_q >> 1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - sdtw_pkg::MOD_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q[sdtw_pkg::CUR_W-1:0];

endmodule

`default_nettype wire

>>> src/sdtw_slot_table.sv
// sdtw_slot_table: per-slot head and tail memory plus occupancy flags
// synchronous memory with registered read data, flags cleared at once
// depends on sdtw_pkg
`timescale 1ns / 1ps
`default_nettype none

module sdtw_slot_table #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6,
  parameter int unsigned NW    = 10
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  sdtw_pkg::slot_cmd_t  cmd_i,
  input  logic [AW-1:0]        raddr_i,
  input  logic [AW-1:0]        waddr_i,
  input  logic [NW-1:0]        whead_i,
  input  logic [NW-1:0]        wtail_i,
  input  logic [AW-1:0]        qaddr_i,
  output logic [NW-1:0]        head_o,
  output logic [NW-1:0]        tail_o,
  output logic                 occ_o
);

  logic [2*NW-1:0]  mem_q [DEPTH];
  logic [2*NW-1:0]  rd_q;
  logic [DEPTH-1:0] occ_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr) begin
      mem_q[waddr_i] <= {whead_i, wtail_i};
    end
    if (cmd_i.rd) begin
      rd_q <= mem_q[raddr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
    end else if (cmd_i.clear) begin
      occ_q <= '0;
    end else if (cmd_i.occ_wr) begin
      occ_q[waddr_i] <= cmd_i.occ_val;
    end
  end

  assign head_o = rd_q[2*NW-1:NW];
  assign tail_o = rd_q[NW-1:0];
  assign occ_o  = occ_q[qaddr_i];

endmodule

`default_nettype wire

>>> src/sdtw_node_store.sv
// sdtw_node_store: event node memory, payload and link fields
// link field can be written on its own; read data registered
// depends on sdtw_pkg
`timescale 1ns / 1ps
`default_nettype none

module sdtw_node_store #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10,
  parameter int unsigned PW    = 34
) (
  input  logic                 clk_i,
  input  sdtw_pkg::node_cmd_t  cmd_i,
  input  logic [AW-1:0]        waddr_i,
  input  logic [PW-1:0]        wpay_i,
  input  logic [AW-1:0]        wnxt_i,
  input  logic                 whas_i,
  input  logic [AW-1:0]        raddr_i,
  output logic [PW-1:0]        rpay_o,
  output logic [AW-1:0]        rnxt_o,
  output logic                 rhas_o
);

  logic [PW-1:0] pay_q  [DEPTH];
  logic [AW:0]   link_q [DEPTH];
  logic [PW-1:0] rpay_q;
  logic [AW:0]   rlink_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_full) begin
      pay_q[waddr_i] <= wpay_i;
    end
    if (cmd_i.wr_full || cmd_i.wr_link) begin
      link_q[waddr_i] <= {wnxt_i, whas_i};
    end
    if (cmd_i.rd) begin
      rpay_q  <= pay_q[raddr_i];
      rlink_q <= link_q[raddr_i];
    end
  end

  assign rpay_o = rpay_q;
  assign rnxt_o = rlink_q[AW:1];
  assign rhas_o = rlink_q[0];

endmodule

`default_nettype wire

>>> bench/spike_delay_timing_wheel_tb.sv
// spike_delay_timing_wheel_tb: self-checking bench for the spike delay timing wheel
// a directed table, then random phases over several ring lengths; an in-bench wheel
// model checks all but typed rows; depends on sdtw_pkg and spike_delay_timing_wheel
`timescale 1ns / 1ps

module spike_delay_timing_wheel_tb;

  localparam int unsigned SLOT_CNT = sdtw_pkg::SLOTS;
  localparam int unsigned NODE_CNT = 1024;
  localparam int unsigned NEURON_W = 20;
  localparam int unsigned IN_W     = ((NEURON_W + 28) / 8) * 8;
  localparam int unsigned OUT_W    = ((NEURON_W + 21) / 8) * 8;
  localparam int unsigned DIR_ROWS = 24;

  typedef struct packed {
    sdtw_pkg::op_e                 op;
    logic [NEURON_W-1:0]           neuron;
    logic [sdtw_pkg::GROUP_W-1:0]  group;
    logic [sdtw_pkg::DELAY_W-1:0]  dly;
    logic [sdtw_pkg::OFFSET_W-1:0] offset;
  } spike_cmd_t;

  typedef struct packed {
    logic                          hit;
    logic [NEURON_W-1:0]           neuron;
    logic [sdtw_pkg::GROUP_W-1:0]  group;
    logic [sdtw_pkg::DELAY_W-1:0]  dly;
    logic                          last;
    sdtw_pkg::status_e             st;
  } spike_res_t;

  typedef struct packed {
    spike_cmd_t cmd;
    logic       typed;
    spike_res_t res;
  } dir_row_t;

  localparam spike_res_t NO_SPIKE  = '{1'b0, '0, '0, '0, 1'b0, sdtw_pkg::ST_OK};
  localparam spike_res_t BAD_DELAY = '{1'b0, '0, '0, '0, 1'b0, sdtw_pkg::ST_DELAY_RANGE};

  logic                        clk_i         = 1'b0;
  logic                        rst_ni        = 1'b0;
  logic                        cfg_we_i      = 1'b0;
  logic [0:0]                  cfg_idx_i     = '0;
  logic [sdtw_pkg::CFG_DW-1:0] cfg_data_i    = '0;
  logic                        s_axis_tvalid = 1'b0;
  logic                        s_axis_tready;
  // neuron_id, group_id, spike_delay, slot_offset
  logic [IN_W-1:0]             s_axis_tdata  = '0;
  // opcode
  logic [1:0]                  s_axis_tuser  = '0;
  logic                        m_axis_tvalid;
  logic                        m_axis_tready = 1'b0;
  // neuron_out, group_out, delay_out
  logic [OUT_W-1:0]            m_axis_tdata;
  // spike_valid, status
  logic [2:0]                  m_axis_tuser;
  // last_in_slot
  logic                        m_axis_tlast;

  spike_delay_timing_wheel #(
    .NODES      (NODE_CNT),
    .NEURON_BITS(NEURON_W)
  ) dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tuser,
    .m_axis_tlast
  );

  // wheel model state
  int unsigned                  cfg_min;
  int unsigned                  cfg_max;
  logic [SLOT_CNT-1:0]          slot_busy;
  int unsigned                  slot_first [SLOT_CNT];
  int unsigned                  slot_last  [SLOT_CNT];
  logic [NEURON_W-1:0]          ev_neuron  [NODE_CNT];
  logic [sdtw_pkg::GROUP_W-1:0] ev_group   [NODE_CNT];
  logic [sdtw_pkg::DELAY_W-1:0] ev_dly     [NODE_CNT];
  int unsigned                  ev_link    [NODE_CNT];
  bit                           ev_more    [NODE_CNT];
  int unsigned                  cur_slot;
  int unsigned                  fresh_cnt;
  int unsigned                  free_head;
  bit                           free_ok;
  int unsigned                  cursor;
  bit                           cursor_ok;

  spike_res_t pending [$];
  dir_row_t   dir_tab [DIR_ROWS];
  bit         quiet = 1'b0;
  int         err_cnt = 0;
  int         n_cmds = 0;
  int         n_results = 0;
  int         n_spikes = 0;
  int         n_full = 0;
  int         n_range = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("spike_delay_timing_wheel_tb NOT OK");
    $finish;
  end

  task automatic report_mismatch(input string what);
    if (err_cnt < 40) $display("%0t mismatch: %s", $time, what);
    err_cnt++;
  endtask

  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return int'($urandom_range(1, 3));
    return int'($urandom_range(8, 40));
  endfunction

  function automatic int unsigned wheel_len();
    int unsigned l;
    l = cfg_min + cfg_max + 1;
    return (l > SLOT_CNT) ? SLOT_CNT : l;
  endfunction

  function automatic void wheel_clear();
    slot_busy = '0;
    cur_slot  = 0;
    fresh_cnt = 0;
    free_head = 0;
    free_ok   = 1'b0;
    cursor    = 0;
    cursor_ok = 1'b0;
  endfunction

  function automatic spike_res_t take_event(input int unsigned idx);
    spike_res_t r;
    r        = NO_SPIKE;
    r.hit    = 1'b1;
    r.neuron = ev_neuron[idx];
    r.group  = ev_group[idx];
    r.dly    = ev_dly[idx];
    r.last   = !ev_more[idx];
    cursor    = ev_link[idx];
    cursor_ok = ev_more[idx];
    return r;
  endfunction

  function automatic spike_res_t wheel_step(input spike_cmd_t c);
    spike_res_t  r;
    int unsigned len;
    int unsigned slot;
    int unsigned idx;
    int          v;
    r   = NO_SPIKE;
    len = wheel_len();
    case (c.op)
      sdtw_pkg::OP_SCHEDULE: begin
        if (c.dly >= len) begin
          r.st = sdtw_pkg::ST_DELAY_RANGE;
        end else if (!free_ok && fresh_cnt >= NODE_CNT) begin
          r.st = sdtw_pkg::ST_POOL_FULL;
        end else begin
          if (free_ok) begin
            idx       = free_head;
            free_head = ev_link[idx];
            free_ok   = ev_more[idx];
          end else begin
            idx = fresh_cnt;
            fresh_cnt++;
          end
          slot = cur_slot + c.dly;
          if (slot >= len) slot -= len;
          if (slot >= len) slot = 0;
          ev_neuron[idx] = c.neuron;
          ev_group[idx]  = c.group;
          ev_dly[idx]    = c.dly;
          ev_link[idx]   = 0;
          ev_more[idx]   = 1'b0;
          if (slot_busy[slot]) begin
            ev_link[slot_last[slot]] = idx;
            ev_more[slot_last[slot]] = 1'b1;
          end else begin
            slot_first[slot] = idx;
            slot_busy[slot]  = 1'b1;
          end
          slot_last[slot] = idx;
        end
      end
      sdtw_pkg::OP_READ_FIRST: begin
        v = int'(cur_slot) + int'($signed(c.offset));
        while (v < 0) v += int'(len);
        while (v >= int'(len)) v -= int'(len);
        if (slot_busy[v]) r = take_event(slot_first[v]);
        else cursor_ok = 1'b0;
      end
      sdtw_pkg::OP_READ_NEXT: begin
        if (cursor_ok && cursor < NODE_CNT) r = take_event(cursor);
      end
      default: begin
        slot = (cur_slot >= len) ? 0 : cur_slot;
        if (slot_busy[slot]) begin
          ev_link[slot_last[slot]] = free_head;
          ev_more[slot_last[slot]] = free_ok;
          free_head = slot_first[slot];
          free_ok   = 1'b1;
        end
        slot_busy[slot] = 1'b0;
        slot++;
        if (slot >= len) slot = 0;
        cur_slot = slot;
      end
    endcase
    return r;
  endfunction

  function automatic spike_cmd_t rand_cmd(input bit pool_mode);
    spike_cmd_t  c;
    int unsigned r;
    int unsigned len;
    len      = wheel_len();
    r        = $urandom_range(0, 99);
    c.neuron = NEURON_W'($urandom);
    c.group  = sdtw_pkg::GROUP_W'($urandom);
    c.offset = sdtw_pkg::OFFSET_W'($urandom);
    if (pool_mode) begin
      if (r < 95) c.op = sdtw_pkg::OP_SCHEDULE;
      else if (r < 98) c.op = sdtw_pkg::OP_READ_FIRST;
      else c.op = sdtw_pkg::OP_READ_NEXT;
    end
    else if (r < 40) c.op = sdtw_pkg::OP_SCHEDULE;
    else if (r < 60) c.op = sdtw_pkg::OP_READ_FIRST;
    else if (r < 85) c.op = sdtw_pkg::OP_READ_NEXT;
    else c.op = sdtw_pkg::OP_ADVANCE;
    if (!pool_mode && $urandom_range(0, 9) == 0)
      c.dly = sdtw_pkg::DELAY_W'($urandom_range(0, 63));
    else c.dly = sdtw_pkg::DELAY_W'($urandom_range(0, len - 1));
    return c;
  endfunction

  // called at a rising edge, returns at the edge where the beat is taken
  task automatic send_cmd(input spike_cmd_t c, input logic typed, input spike_res_t typed_res);
    int         g;
    spike_res_t e;
    g = quiet ? 0 : pick_gap();
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_W'({c.offset, c.dly, c.group, c.neuron});
    s_axis_tuser  <= c.op;
    do @(posedge clk_i); while (!s_axis_tready);
    e = wheel_step(c);
    if (typed) e = typed_res;
    if (e.hit) n_spikes++;
    if (e.st == sdtw_pkg::ST_POOL_FULL) n_full++;
    if (e.st == sdtw_pkg::ST_DELAY_RANGE) n_range++;
    pending = {pending, e};
    n_cmds++;
  endtask

  task automatic wait_drained();
    int guard;
    guard = 0;
    s_axis_tvalid <= 1'b0;
    while (pending.size() != 0 && guard < 20000) begin
      @(posedge clk_i);
      guard++;
    end
    if (pending.size() != 0) begin
      report_mismatch($sformatf("%0d expected results never arrived", pending.size()));
      pending.delete();
    end
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input sdtw_pkg::cfg_idx_e idx,
                           input logic [sdtw_pkg::CFG_DW-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == sdtw_pkg::CFG_MIN_DELAY) cfg_min = int'(val[sdtw_pkg::MIN_W-1:0]);
    else cfg_max = int'(val[sdtw_pkg::MAX_W-1:0]);
    wheel_clear();
    @(posedge clk_i);
  endtask

  task automatic run_phase(input logic [sdtw_pkg::CFG_DW-1:0] min_v,
                           input logic [sdtw_pkg::CFG_DW-1:0] max_v,
                           input int items, input int pool_items);
    spike_cmd_t c;
    wait_drained();
    write_reg(sdtw_pkg::CFG_MIN_DELAY, min_v);
    write_reg(sdtw_pkg::CFG_MAX_DELAY, max_v);
    for (int i = 0; i < items; i++) begin
      if (i % 50 == 0) quiet = ($urandom_range(0, 3) == 0);
      // halfway through, the sender holds off until the wheel has answered everything
      if (i == items / 2) wait_drained();
      c = rand_cmd(i < pool_items);
      send_cmd(c, 1'b0, NO_SPIKE);
    end
  endtask

  initial begin : result_sink
    spike_res_t want;
    spike_res_t got;
    int         stall_left;
    int         g;
    bit         long_done;
    stall_left = 0;
    long_done  = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) begin
        got.hit    = m_axis_tuser[0];
        got.st     = sdtw_pkg::status_e'(m_axis_tuser[2:1]);
        got.neuron = m_axis_tdata[NEURON_W-1:0];
        got.group  = m_axis_tdata[NEURON_W+sdtw_pkg::GROUP_W-1:NEURON_W];
        got.dly    = m_axis_tdata[NEURON_W+sdtw_pkg::GROUP_W+sdtw_pkg::DELAY_W-1:
                                  NEURON_W+sdtw_pkg::GROUP_W];
        got.last   = m_axis_tlast;
        if (pending.size() == 0) begin
          report_mismatch("result beat with nothing expected");
        end else begin
          want = pending.pop_front();
          if (got.hit !== want.hit)
            report_mismatch($sformatf("beat %0d spike_valid %b exp %b", n_results, got.hit,
                                      want.hit));
          if (got.neuron !== want.neuron)
            report_mismatch($sformatf("beat %0d neuron_out %h exp %h", n_results, got.neuron,
                                      want.neuron));
          if (got.group !== want.group)
            report_mismatch($sformatf("beat %0d group_out %h exp %h", n_results, got.group,
                                      want.group));
          if (got.dly !== want.dly)
            report_mismatch($sformatf("beat %0d delay_out %0d exp %0d", n_results, got.dly,
                                      want.dly));
          if (got.last !== want.last)
            report_mismatch($sformatf("beat %0d last_in_slot %b exp %b", n_results, got.last,
                                      want.last));
          if (got.st !== want.st)
            report_mismatch($sformatf("beat %0d status %0d exp %0d", n_results, got.st,
                                      want.st));
        end
        n_results++;
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (!long_done && n_results >= 150) begin
        // long hold-off so the wheel backs up and stalls its input
        long_done  = 1'b1;
        stall_left = 300;
        m_axis_tready <= 1'b0;
      end else begin
        g = quiet ? 0 : pick_gap();
        if (g > 0) begin
          stall_left = g - 1;
          m_axis_tready <= 1'b0;
        end else begin
          m_axis_tready <= 1'b1;
        end
      end
    end
  end

  initial begin : stimulus
    cfg_min = 1;
    cfg_max = 20;
    wheel_clear();

    // reset ring length 22, current slot 0
    dir_tab[0]  = '{'{sdtw_pkg::OP_READ_FIRST, 20'h00000, 8'h00, 6'd0,  7'h00}, 1'b1, NO_SPIKE};
    dir_tab[1]  = '{'{sdtw_pkg::OP_READ_NEXT,  20'h00000, 8'h00, 6'd0,  7'h00}, 1'b1, NO_SPIKE};
    dir_tab[2]  = '{'{sdtw_pkg::OP_ADVANCE,    20'h00000, 8'h00, 6'd0,  7'h00}, 1'b1, NO_SPIKE};
    dir_tab[3]  = '{'{sdtw_pkg::OP_SCHEDULE,   20'hfffff, 8'hff, 6'd21, 7'h00}, 1'b1, NO_SPIKE};
    dir_tab[4]  = '{'{sdtw_pkg::OP_SCHEDULE,   20'h00000, 8'h00, 6'd0,  7'h7f}, 1'b1, NO_SPIKE};
    dir_tab[5]  = '{'{sdtw_pkg::OP_SCHEDULE,   20'h00001, 8'h01, 6'd22, 7'h00}, 1'b1, BAD_DELAY};
    dir_tab[6]  = '{'{sdtw_pkg::OP_SCHEDULE,   20'hfffff, 8'hff, 6'd63, 7'h7f}, 1'b1, BAD_DELAY};
    dir_tab[7]  = '{'{sdtw_pkg::OP_SCHEDULE,   20'h5a5a5, 8'ha5, 6'd21, 7'h00}, 1'b1, NO_SPIKE};
    dir_tab[8]  = '{'{sdtw_pkg::OP_READ_FIRST, 20'h00000, 8'h00, 6'd0,  7'd21}, 1'b0, NO_SPIKE};
    dir_tab[9]  = '{'{sdtw_pkg::OP_READ_NEXT,  20'h00000, 8'h00, 6'd0,  7'h00}, 1'b0, NO_SPIKE};
    dir_tab[10] = '{'{sdtw_pkg::OP_READ_NEXT,  20'h00000, 8'h00, 6'd0,  7'h00}, 1'b1, NO_SPIKE};
    dir_tab[11] = '{'{sdtw_pkg::OP_READ_FIRST, 20'hfffff, 8'hff, 6'd63, 7'h7f}, 1'b0, NO_SPIKE};
    dir_tab[12] = '{'{sdtw_pkg::OP_READ_FIRST, 20'h00000, 8'h00, 6'd0,  7'h00}, 1'b0, NO_SPIKE};
    dir_tab[13] = '{'{sdtw_pkg::OP_READ_FIRST, 20'h00000, 8'h00, 6'd0,  7'h41}, 1'b0, NO_SPIKE};
    dir_tab[14] = '{'{sdtw_pkg::OP_READ_FIRST, 20'h00000, 8'h00, 6'd0,  7'h3f}, 1'b0, NO_SPIKE};
    dir_tab[15] = '{'{sdtw_pkg::OP_READ_FIRST, 20'h00000, 8'h00, 6'd0,  7'h40}, 1'b0, NO_SPIKE};
    dir_tab[16] = '{'{sdtw_pkg::OP_READ_FIRST, 20'h00000, 8'h00, 6'd0,  7'd21}, 1'b0, NO_SPIKE};
    dir_tab[17] = '{'{sdtw_pkg::OP_ADVANCE,    20'hfffff, 8'hff, 6'd63, 7'h7f}, 1'b1, NO_SPIKE};
    dir_tab[18] = '{'{sdtw_pkg::OP_READ_NEXT,  20'h00000, 8'h00, 6'd0,  7'h00}, 1'b0, NO_SPIKE};
    dir_tab[19] = '{'{sdtw_pkg::OP_SCHEDULE,   20'h12345, 8'h3c, 6'd20, 7'h00}, 1'b1, NO_SPIKE};
    dir_tab[20] = '{'{sdtw_pkg::OP_READ_FIRST, 20'h00000, 8'h00, 6'd0,  7'h7e}, 1'b0, NO_SPIKE};
    dir_tab[21] = '{'{sdtw_pkg::OP_READ_NEXT,  20'h00000, 8'h00, 6'd0,  7'h00}, 1'b0, NO_SPIKE};
    dir_tab[22] = '{'{sdtw_pkg::OP_READ_NEXT,  20'h00000, 8'h00, 6'd0,  7'h00}, 1'b0, NO_SPIKE};
    dir_tab[23] = '{'{sdtw_pkg::OP_READ_NEXT,  20'h00000, 8'h00, 6'd0,  7'h00}, 1'b0, NO_SPIKE};

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DIR_ROWS; i++)
      send_cmd(dir_tab[i].cmd, dir_tab[i].typed, dir_tab[i].res);

    run_phase(6'd0,  6'd0,  80,   0);
    run_phase(6'd31, 6'd63, 130,  0);
    run_phase(6'd5,  6'd9,  130,  0);
    // no advances for a long stretch, so the node pool runs dry
    run_phase(6'd1,  6'd20, 1250, 1150);
    run_phase(6'd31, 6'd0,  80,   0);
    run_phase(6'd0,  6'd32, 80,   0);

    wait_drained();
    repeat (20) @(posedge clk_i);

    $display("%0d commands over seven ring settings, lengths 1 to 64 and a capped one",
             n_cmds);
    $display("%0d results checked: %0d spikes read, %0d pool-full drops, %0d delay rejects",
             n_results, n_spikes, n_full, n_range);
    if (err_cnt == 0) begin
      $display("spike_delay_timing_wheel_tb OK");
    end else begin
      $display("spike_delay_timing_wheel_tb NOT OK");
    end
    $finish;
  end

endmodule

>>> spike_delay_timing_wheel.f
src/sdtw_pkg.sv
src/sdtw_slot_mod.sv
src/sdtw_slot_table.sv
src/sdtw_node_store.sv
src/spike_delay_timing_wheel.sv
bench/spike_delay_timing_wheel_tb.sv
